// ===== src/sfsu_pkg.sv =====
// sfsu_pkg: shared constants and types for the frame sync and channel unpack block
// used by sfsu_byte_cell, sfsu_chan_cell, sfsu_drain and the top level
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sfsu_pkg;

   // byte and frame geometry
   localparam int unsigned BYTE_W      = 8;
   localparam logic [7:0]  HDR_BYTE    = 8'h0F;
   localparam int unsigned SKIP_TOTAL  = 25;
   localparam int unsigned STORE_DEPTH = 24;
   localparam int unsigned DATA_BYTES  = 22;
   localparam int unsigned FLAG_POS    = 23;
   localparam int unsigned POS_W       = 5;
   localparam int unsigned SKIP_W      = 5;

   // channel geometry
   localparam int unsigned NUM_CH      = 16;
   localparam int unsigned CH_W        = 11;
   localparam int unsigned IDX_W       = 4;
   localparam int unsigned FRAME_BITS  = NUM_CH * CH_W;

   // flag byte bits
   localparam int unsigned FLAG_D17    = 0;
   localparam int unsigned FLAG_D18    = 1;
   localparam int unsigned FLAG_LOST   = 2;
   localparam int unsigned FLAG_FSAFE  = 3;

   // signal status codes
   localparam logic [1:0]  STATUS_OK    = 2'd0;
   localparam logic [1:0]  STATUS_LOST  = 2'd1;
   localparam logic [1:0]  STATUS_FSAFE = 2'd2;

   // frame hand-over from the sync logic to the drain chain
   typedef struct packed {
      logic              load;
      logic [BYTE_W-1:0] flags;
      logic [BYTE_W-1:0] footer;
   } load_ctl_type;

endpackage

`default_nettype wire

// ===== src/sfsu_byte_cell.sv =====
// sfsu_byte_cell: one byte cell of the capture line
// passes its byte to the next cell down on every shift; uses sfsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfsu_byte_cell (
   input  wire logic                        clock,
   input  wire logic                        shift_en,
   input  wire logic [sfsu_pkg::BYTE_W-1:0] shift_in,
   output logic      [sfsu_pkg::BYTE_W-1:0] data_out
);

   logic [sfsu_pkg::BYTE_W-1:0] data_ff;
   logic [sfsu_pkg::BYTE_W-1:0] data_in;

   // take the neighbour's byte on a shift
   always_comb begin
      data_in = shift_en ? shift_in : data_ff;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

// ===== src/sfsu_chan_cell.sv =====
// sfsu_chan_cell: one 11-bit channel cell of the drain chain
// loads its channel from a finished frame, then shifts towards the output; uses sfsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfsu_chan_cell (
   input  wire logic                      clock,
   input  wire logic                      load,
   input  wire logic [sfsu_pkg::CH_W-1:0] load_data,
   input  wire logic                      shift_en,
   input  wire logic [sfsu_pkg::CH_W-1:0] shift_in,
   output logic      [sfsu_pkg::CH_W-1:0] data_out
);

   logic [sfsu_pkg::CH_W-1:0] data_ff;
   logic [sfsu_pkg::CH_W-1:0] data_in;

   // load has priority, the two never coincide
   always_comb begin
      data_in = data_ff;
      if (load) begin
         data_in = load_data;
      end else if (shift_en) begin
         data_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

// ===== src/sfsu_drain.sv =====
// sfsu_drain: chain of 16 channel cells that drains a finished frame, one result per transfer
// depends on sfsu_pkg and sfsu_chan_cell
`timescale 1ns / 1ps
`default_nettype none

module sfsu_drain (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire sfsu_pkg::load_ctl_type          load_ctl,
   input  wire logic [sfsu_pkg::FRAME_BITS-1:0] load_bits,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_valid,
   output logic      [sfsu_pkg::IDX_W-1:0]      rsp_channel_index,
   output logic      [sfsu_pkg::CH_W-1:0]       rsp_channel_value,
   output logic                                 rsp_digital_one,
   output logic                                 rsp_digital_two,
   output logic      [1:0]                      rsp_signal_status,
   output logic      [sfsu_pkg::BYTE_W-1:0]     rsp_footer_byte,
   output logic                                 rsp_last_of_frame
);

   localparam logic [sfsu_pkg::IDX_W-1:0] LAST_IDX = sfsu_pkg::IDX_W'(sfsu_pkg::NUM_CH - 1);

   logic                          busy_ff, busy_in;
   logic [sfsu_pkg::IDX_W-1:0]    count_ff, count_in;
   logic [sfsu_pkg::BYTE_W-1:0]   flags_ff, flags_in;
   logic [sfsu_pkg::BYTE_W-1:0]   footer_ff, footer_in;
   logic                          xfer;
   logic [sfsu_pkg::CH_W-1:0]     chan_q [sfsu_pkg::NUM_CH];
   logic [sfsu_pkg::CH_W-1:0]     chain_in [sfsu_pkg::NUM_CH];

   assign xfer = busy_ff && !rsp_stall;

   // row of channel cells, channel 0 sits at the output end
   for (genvar k = 0; k < sfsu_pkg::NUM_CH; k++) begin : g_cell
      if (k == sfsu_pkg::NUM_CH - 1) begin : g_end
         assign chain_in[k] = '0;
      end else begin : g_mid
         assign chain_in[k] = chan_q[k+1];
      end
      sfsu_chan_cell u_cell (
         .clock     (clock),
         .load      (load_ctl.load),
         .load_data (load_bits[k*sfsu_pkg::CH_W +: sfsu_pkg::CH_W]),
         .shift_en  (xfer),
         .shift_in  (chain_in[k]),
         .data_out  (chan_q[k])
      );
   end

   // result counter and frame-wide fields
   always_comb begin
      busy_in   = busy_ff;
      count_in  = count_ff;
      flags_in  = flags_ff;
      footer_in = footer_ff;
      if (load_ctl.load) begin
         busy_in   = 1'b1;
         count_in  = '0;
         flags_in  = load_ctl.flags;
         footer_in = load_ctl.footer;
      end else if (xfer) begin
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_IDX) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      flags_ff  <= flags_in;
      footer_ff <= footer_in;
   end

   // result fields
   always_comb begin
      if (flags_ff[sfsu_pkg::FLAG_FSAFE]) begin
         rsp_signal_status = sfsu_pkg::STATUS_FSAFE;
      end else if (flags_ff[sfsu_pkg::FLAG_LOST]) begin
         rsp_signal_status = sfsu_pkg::STATUS_LOST;
      end else begin
         rsp_signal_status = sfsu_pkg::STATUS_OK;
      end
   end

   assign rsp_valid         = busy_ff;
   assign rsp_channel_index = count_ff;
   assign rsp_channel_value = chan_q[0];
   assign rsp_digital_one   = flags_ff[sfsu_pkg::FLAG_D17];
   assign rsp_digital_two   = flags_ff[sfsu_pkg::FLAG_D18];
   assign rsp_footer_byte   = footer_ff;
   assign rsp_last_of_frame = (count_ff == LAST_IDX);

endmodule

`default_nettype wire

// ===== src/sbus_frame_sync_and_channel_unpack.sv =====
// sbus_frame_sync_and_channel_unpack: header hunt, frame capture and 16-channel unpack
// depends on sfsu_pkg, sfsu_byte_cell and sfsu_drain
//
//  channel | ports                      | width        | direction
//  --------+----------------------------+--------------+----------
//  req     | req_valid/req_stall        | rx_byte 8    | in
//  rsp     | rsp_valid/rsp_stall        | 4+11+1+1+2+8+1 | out
//
// one received byte is taken per cycle unless req_stall is high; a captured
// byte other than the footer enters the 24-cell capture line in its transfer cycle
// a good frame's footer moves the frame into the 16-cell drain chain; it gives one
// result per cycle while rsp_stall is low, 16 in all, as the next frame is captured
// req_stall is high only while the footer byte is due and the drain chain still
// holds results of the previous frame
// synchronous reset returns to header hunt and empties the drain chain
`timescale 1ns / 1ps
`default_nettype none

module sbus_frame_sync_and_channel_unpack (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [sfsu_pkg::BYTE_W-1:0]     req_rx_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [sfsu_pkg::IDX_W-1:0]      rsp_channel_index,
   output logic      [sfsu_pkg::CH_W-1:0]       rsp_channel_value,
   output logic                                 rsp_digital_one,
   output logic                                 rsp_digital_two,
   output logic      [1:0]                      rsp_signal_status,
   output logic      [sfsu_pkg::BYTE_W-1:0]     rsp_footer_byte,
   output logic                                 rsp_last_of_frame
);

   typedef enum logic [2:0] {
      ST_HUNT = 3'b001,
      ST_SKIP = 3'b010,
      ST_CAPT = 3'b100
   } state_type;

   localparam logic [sfsu_pkg::POS_W-1:0]  FOOTER_POS =
      sfsu_pkg::POS_W'(sfsu_pkg::STORE_DEPTH);
   localparam logic [sfsu_pkg::SKIP_W-1:0] SKIP_END =
      sfsu_pkg::SKIP_W'(sfsu_pkg::SKIP_TOTAL);

   state_type                      state_ff, state_in;
   logic [sfsu_pkg::SKIP_W-1:0]    skip_ff, skip_in;
   logic [sfsu_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic                           hdr_ok_ff, hdr_ok_in;
   logic                           xfer;
   logic                           shift_en;
   logic                           drain_busy;
   logic [sfsu_pkg::BYTE_W-1:0]    cell_q [sfsu_pkg::STORE_DEPTH];
   logic [sfsu_pkg::BYTE_W-1:0]    cell_in [sfsu_pkg::STORE_DEPTH];
   logic [sfsu_pkg::FRAME_BITS-1:0] frame_bits;
   sfsu_pkg::load_ctl_type         load_ctl;

   assign req_stall = (state_ff == ST_CAPT) && (pos_ff == FOOTER_POS) && drain_busy;
   assign xfer      = req_valid && !req_stall;
   assign shift_en  = xfer && (state_ff == ST_CAPT) && (pos_ff != FOOTER_POS);

   // capture line, newest byte enters at the top, frame byte 0 ends in cell 0
   for (genvar i = 0; i < sfsu_pkg::STORE_DEPTH; i++) begin : g_byte
      if (i == sfsu_pkg::STORE_DEPTH - 1) begin : g_top
         assign cell_in[i] = req_rx_byte;
      end else begin : g_mid
         assign cell_in[i] = cell_q[i+1];
      end
      sfsu_byte_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .shift_in (cell_in[i]),
         .data_out (cell_q[i])
      );
   end

   // proportional channel bits, frame bytes 1 to 22 little-endian
   for (genvar j = 0; j < sfsu_pkg::DATA_BYTES; j++) begin : g_bits
      assign frame_bits[j*sfsu_pkg::BYTE_W +: sfsu_pkg::BYTE_W] = cell_q[j+1];
   end

   // sync state machine
   always_comb begin
      state_in      = state_ff;
      skip_in       = skip_ff;
      pos_in        = pos_ff;
      hdr_ok_in     = hdr_ok_ff;
      load_ctl.load   = 1'b0;
      load_ctl.flags  = cell_q[sfsu_pkg::FLAG_POS];
      load_ctl.footer = req_rx_byte;
      unique case (state_ff)
         ST_HUNT: begin
            if (xfer && (req_rx_byte == sfsu_pkg::HDR_BYTE)) begin
               state_in = ST_SKIP;
               skip_in  = 5'd1;
            end
         end
         ST_SKIP: begin
            if (xfer) begin
               skip_in = skip_ff + 1'b1;
               if (skip_in >= SKIP_END) begin
                  state_in = ST_CAPT;
                  pos_in   = '0;
               end
            end
         end
         ST_CAPT: begin
            if (xfer) begin
               if (pos_ff != FOOTER_POS) begin
                  if (pos_ff == '0) begin
                     hdr_ok_in = (req_rx_byte == sfsu_pkg::HDR_BYTE);
                  end
                  pos_in = pos_ff + 1'b1;
               end else begin
                  pos_in = '0;
                  if (hdr_ok_ff) begin
                     load_ctl.load = 1'b1;
                  end else begin
                     state_in = ST_HUNT;
                     skip_in  = '0;
                  end
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_HUNT;
         skip_ff   <= '0;
         pos_ff    <= '0;
         hdr_ok_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         skip_ff   <= skip_in;
         pos_ff    <= pos_in;
         hdr_ok_ff <= hdr_ok_in;
      end
   end

   // result side
   sfsu_drain u_drain (
      .clock             (clock),
      .reset             (reset),
      .load_ctl          (load_ctl),
      .load_bits         (frame_bits),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (drain_busy),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_digital_one   (rsp_digital_one),
      .rsp_digital_two   (rsp_digital_two),
      .rsp_signal_status (rsp_signal_status),
      .rsp_footer_byte   (rsp_footer_byte),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   assign rsp_valid = drain_busy;

endmodule

`default_nettype wire
